// ===== hdl/mrfe_pkg.sv =====
// Shared types and constants of the matrix rotate and flip engine.
// Depends on nothing; every other file takes names from here by scope.
package mrfe_pkg;

    localparam int MAX_DIM     = 16;
    localparam int DATA_BITS   = 32;
    localparam int DIM_REG_W   = 5;
    localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EFF_W       = $clog2(MAX_DIM + 1);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS = CFG_IDX_W'(1);

    localparam logic MOVE_ROTATE = 1'b0;
    localparam logic MOVE_FLIP   = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_MOVE  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef struct packed {
        logic mirror_cols;
        logic mirror_rows;
        logic swap;
    } t_orient;

    typedef struct packed {
        t_mode                        mode;
        logic signed [DATA_BITS-1:0]  element_value;
        logic                         move_kind;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_BITS-1:0]  out_value;
        logic [DIM_REG_W-1:0]         out_rows;
        logic [DIM_REG_W-1:0]         out_cols;
        logic                         is_last;
    } t_out_item;

endpackage

// ===== hdl/matrix_rotate_flip_engine.sv =====
// Top level of the matrix rotate and flip engine: element store, orientation
// tracking, readout address generation and the output register.
// Depends on mrfe_pkg.

// The engine takes one item per clock cycle unless the input stalls. Load
// items write one word of a 256-word single-write, single-read memory; move
// and clear items update small registers. A read item looks up its element
// in the memory in the cycle it is accepted and presents it on the output
// through the registered memory read and then the output register, which
// can be held back by a stalled output. The input stalls only when a finished
// read waits behind a stalled output. There is no clearing pass after reset;
// reading an element never loaded returns an undefined value.
module matrix_rotate_flip_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mrfe_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mrfe_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mrfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mrfe_pkg::DIM_REG_W-1:0]      i_cfg_data
);

    function automatic logic [mrfe_pkg::EFF_W-1:0] f_eff_dim(
        input logic [mrfe_pkg::DIM_REG_W-1:0] v
    );
        logic [mrfe_pkg::EFF_W-1:0] d;
        if (v == '0) begin
            d = mrfe_pkg::EFF_W'(1);
        end else if (int'(v) > mrfe_pkg::MAX_DIM) begin
            d = mrfe_pkg::EFF_W'(mrfe_pkg::MAX_DIM);
        end else begin
            d = mrfe_pkg::EFF_W'(v);
        end
        return d;
    endfunction

    logic [mrfe_pkg::DATA_BITS-1:0]   r_mem [mrfe_pkg::STORE_DEPTH];
    logic [mrfe_pkg::DATA_BITS-1:0]   r_rd_data;

    logic [mrfe_pkg::DIM_REG_W-1:0]   r_src_rows;
    logic [mrfe_pkg::DIM_REG_W-1:0]   r_src_cols;
    mrfe_pkg::t_orient                r_orient,   n_orient;
    logic [mrfe_pkg::CNT_W-1:0]       r_load_cnt, n_load_cnt;
    logic [mrfe_pkg::IDX_W-1:0]       r_row,      n_row;
    logic [mrfe_pkg::IDX_W-1:0]       r_col,      n_col;

    logic                             r_pend;
    logic [mrfe_pkg::DIM_REG_W-1:0]   r_pend_rows;
    logic [mrfe_pkg::DIM_REG_W-1:0]   r_pend_cols;
    logic                             r_pend_last;
    logic                             r_out_valid;
    mrfe_pkg::t_out_item              r_out;

    logic                             w_in_acc;
    logic                             w_pend_move;
    logic                             w_rd_en;
    logic                             w_wr_en;
    logic [mrfe_pkg::ADDR_W-1:0]      w_rd_addr;
    logic [mrfe_pkg::EFF_W-1:0]       w_r;
    logic [mrfe_pkg::EFF_W-1:0]       w_c;
    logic [mrfe_pkg::EFF_W-1:0]       w_orows;
    logic [mrfe_pkg::EFF_W-1:0]       w_ocols;
    logic                             w_wrap;
    logic [mrfe_pkg::IDX_W-1:0]       w_row0;
    logic [mrfe_pkg::IDX_W-1:0]       w_col0;
    logic [mrfe_pkg::IDX_W-1:0]       w_a;
    logic [mrfe_pkg::IDX_W-1:0]       w_b;
    logic [mrfe_pkg::IDX_W-1:0]       w_src_r;
    logic [mrfe_pkg::IDX_W-1:0]       w_src_c;
    logic                             w_last;

    assign w_pend_move = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_pend && !w_pend_move;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_r = f_eff_dim(r_src_rows);
    assign w_c = f_eff_dim(r_src_cols);

    // readout position and source address
    always_comb begin
        w_orows = r_orient.swap ? w_c : w_r;
        w_ocols = r_orient.swap ? w_r : w_c;
        w_wrap  = (mrfe_pkg::EFF_W'(r_row) >= w_orows)
               || (mrfe_pkg::EFF_W'(r_col) >= w_ocols);
        w_row0  = w_wrap ? '0 : r_row;
        w_col0  = w_wrap ? '0 : r_col;
        w_a     = r_orient.swap ? w_col0 : w_row0;
        w_b     = r_orient.swap ? w_row0 : w_col0;
        w_src_r = r_orient.mirror_rows
                ? mrfe_pkg::IDX_W'(w_r - mrfe_pkg::EFF_W'(1) - mrfe_pkg::EFF_W'(w_a))
                : w_a;
        w_src_c = r_orient.mirror_cols
                ? mrfe_pkg::IDX_W'(w_c - mrfe_pkg::EFF_W'(1) - mrfe_pkg::EFF_W'(w_b))
                : w_b;
        w_rd_addr = mrfe_pkg::ADDR_W'(w_src_r) * mrfe_pkg::ADDR_W'(w_c)
                  + mrfe_pkg::ADDR_W'(w_src_c);
        w_last  = (mrfe_pkg::EFF_W'(w_row0) == w_orows - mrfe_pkg::EFF_W'(1))
               && (mrfe_pkg::EFF_W'(w_col0) == w_ocols - mrfe_pkg::EFF_W'(1));
    end

    assign w_rd_en = w_in_acc && (i_in_item.mode == mrfe_pkg::MODE_READ);
    assign w_wr_en = w_in_acc && (i_in_item.mode == mrfe_pkg::MODE_LOAD)
                  && (r_load_cnt < mrfe_pkg::CNT_W'(w_r) * mrfe_pkg::CNT_W'(w_c));

    always_comb begin
        n_orient   = r_orient;
        n_load_cnt = r_load_cnt;
        n_row      = r_row;
        n_col      = r_col;
        if (w_in_acc) begin
            case (i_in_item.mode)
                mrfe_pkg::MODE_LOAD: begin
                    if (w_wr_en) begin
                        n_load_cnt = r_load_cnt + mrfe_pkg::CNT_W'(1);
                    end
                end
                mrfe_pkg::MODE_MOVE: begin
                    if (i_in_item.move_kind == mrfe_pkg::MOVE_ROTATE) begin
                        n_orient.swap        = !r_orient.swap;
                        n_orient.mirror_rows = r_orient.mirror_cols;
                        n_orient.mirror_cols = !r_orient.mirror_rows;
                    end else begin
                        n_orient.mirror_rows = !r_orient.mirror_rows;
                    end
                end
                mrfe_pkg::MODE_READ: begin
                    if (w_last) begin
                        n_row = '0;
                        n_col = '0;
                    end else if (mrfe_pkg::EFF_W'(w_col0) + mrfe_pkg::EFF_W'(1) >= w_ocols) begin
                        n_row = w_row0 + mrfe_pkg::IDX_W'(1);
                        n_col = '0;
                    end else begin
                        n_row = w_row0;
                        n_col = w_col0 + mrfe_pkg::IDX_W'(1);
                    end
                end
                mrfe_pkg::MODE_CLEAR: begin
                    n_orient   = '0;
                    n_load_cnt = '0;
                    n_row      = '0;
                    n_col      = '0;
                end
                default: begin
                    n_orient = r_orient;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_load_cnt[mrfe_pkg::ADDR_W-1:0]] <= i_in_item.element_value;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_rows  <= mrfe_pkg::DIM_REG_W'(1);
            r_src_cols  <= mrfe_pkg::DIM_REG_W'(1);
            r_orient    <= '0;
            r_load_cnt  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mrfe_pkg::CFG_SRC_ROWS) begin
                    r_src_rows <= i_cfg_data;
                end else if (i_cfg_index == mrfe_pkg::CFG_SRC_COLS) begin
                    r_src_cols <= i_cfg_data;
                end
            end
            r_orient   <= n_orient;
            r_load_cnt <= n_load_cnt;
            r_row      <= n_row;
            r_col      <= n_col;
            if (w_rd_en) begin
                r_pend <= 1'b1;
            end else if (w_pend_move) begin
                r_pend <= 1'b0;
            end
            if (w_pend_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_pend_rows <= mrfe_pkg::DIM_REG_W'(w_orows);
            r_pend_cols <= mrfe_pkg::DIM_REG_W'(w_ocols);
            r_pend_last <= w_last;
        end
        if (w_pend_move) begin
            r_out.out_value <= r_rd_data;
            r_out.out_rows  <= r_pend_rows;
            r_out.out_cols  <= r_pend_cols;
            r_out.is_last   <= r_pend_last;
        end
    end

    a_read_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> r_pend)
        else $error("accepted read item left no pending lookup");

    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_pend_move) |=> (r_pend && $stable(r_pend_rows) && $stable(r_pend_last)))
        else $error("blocked lookup was lost or changed");

    a_out_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.out_rows != '0 && o_out_item.out_cols != '0))
        else $error("output item carries a zero dimension");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_item.mode == mrfe_pkg::MODE_CLEAR)
        |=> (r_orient == '0 && r_load_cnt == '0 && r_row == '0 && r_col == '0))
        else $error("clear item did not reset orientation and counters");

endmodule
